/* hw/rtl/perlin_noise_2d_height_top_assert.svh */
// Assertion macros used by the top-level RTL
`ifndef PERLIN_NOISE_2D_HEIGHT_TOP_ASSERT_SVH
`define PERLIN_NOISE_2D_HEIGHT_TOP_ASSERT_SVH

// same-cycle implication
`define PN2H_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pn2h: same-cycle check failed");

// next-cycle implication
`define PN2H_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pn2h: next-cycle check failed");

`endif

/* hw/rtl/pn2h_pkg.sv */
`default_nettype none
package pn2h_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 12;
	localparam int DIM_W     = 13;
	localparam int QUO_W     = COORD_W + FRAC_BITS;
	localparam int REM_W     = 12;
	localparam int DIV_STEPS = 4;
	localparam int DIV_DEPTH = QUO_W / DIV_STEPS;
	localparam int MAX_DIM   = 4096;
	localparam int TABLE_W   = 8;
	localparam int TABLE_SIZE = 256;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FREQUENCY    = 2'd2;
	localparam logic [1:0] CFG_AMPLITUDE    = 2'd3;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] num;
	} div_t;

	function automatic div_t div_step(div_t a, logic [DIM_W-1:0] d);
		div_t r;
		logic [DIM_W-1:0] t;
		r = a;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.num[QUO_W-1]};
			r.num = {r.num[QUO_W-2:0], 1'b0};
			if (t >= d) begin
				t = t - d;
				r.num[0] = 1'b1;
			end
			r.rem = t[REM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0)
			r = DIM_W'(1);
		else if (d > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic signed [18:0] grad_dot(logic [2:0] h,
			logic signed [17:0] dx, logic signed [17:0] dy);
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic signed [18:0] r;
		x = 19'(dx);
		y = 19'(dy);
		case (h)
			3'd0: r = x + y;
			3'd1: r = x - y;
			3'd2: r = y - x;
			3'd3: r = -x - y;
			3'd4: r = x;
			3'd5: r = -x;
			3'd6: r = y;
			3'd7: r = -y;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/pn2h_coord.sv */
`default_nettype none
module pn2h_coord (
	input  logic        clk,
	input  logic        adv,
	input  logic [11:0] coord,
	input  logic [12:0] dim,
	input  logic [15:0] freq,
	output logic [7:0]  cell_idx,
	output logic [15:0] frac
);
	logic [12:0]         dcl;
	pn2h_pkg::div_t      st0;
	pn2h_pkg::div_t      st_s [1:pn2h_pkg::DIV_DEPTH];
	logic signed [28:0]  qs;
	logic signed [45:0]  prod_s8;

	assign dcl = pn2h_pkg::clamp_dim(dim);

	always_comb begin
		st0.rem = '0;
		st0.num = {coord, 16'b0};
	end

	assign qs = $signed({1'b0, st_s[pn2h_pkg::DIV_DEPTH].num}) - 29'sd32768;

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[1] <= pn2h_pkg::div_step(st0, dcl);
			for (int k = 2; k <= pn2h_pkg::DIV_DEPTH; k++)
				st_s[k] <= pn2h_pkg::div_step(st_s[k-1], dcl);
			prod_s8 <= qs * $signed({1'b0, freq});
		end
	end

	assign cell_idx = prod_s8[31:24];
	assign frac     = prod_s8[23:8];
endmodule
`default_nettype wire

/* hw/rtl/pn2h_fade.sv */
`default_nettype none
module pn2h_fade (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] t,
	output logic [16:0] u
);
	logic signed [16:0] ts;
	logic signed [21:0] k;
	logic [31:0]        t2p_s1;
	logic signed [38:0] pp_s1;
	logic [15:0]        t_s1;
	logic signed [22:0] psum;
	logic [31:0]        t3p_s2;
	logic [19:0]        p_s2;
	logic [35:0]        up;
	logic [16:0]        u_s3;

	assign ts   = $signed({1'b0, t});
	assign k    = 22'sd6 * 22'(ts) - 22'sd983040;
	assign psum = 23'(pp_s1 >>> 16) + 23'sd655360;
	assign up   = t3p_s2[31:16] * p_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			t2p_s1 <= t * t;
			pp_s1  <= ts * k;
			t_s1   <= t;
			t3p_s2 <= t2p_s1[31:16] * t_s1;
			p_s2   <= psum[19:0];
			u_s3   <= up[32:16];
		end
	end

	assign u = u_s3;
endmodule
`default_nettype wire

/* hw/rtl/pn2h_hash.sv */
`default_nettype none
module pn2h_hash (
	input  logic       clk,
	input  logic       adv,
	input  logic       ld,
	input  logic [7:0] widx,
	input  logic [7:0] wval,
	input  logic [7:0] x0,
	input  logic [7:0] y0,
	output logic [2:0] h_aa,
	output logic [2:0] h_ab,
	output logic [2:0] h_ba,
	output logic [2:0] h_bb
);
	logic [7:0] perm_a [pn2h_pkg::TABLE_SIZE];
	logic [7:0] perm_b [pn2h_pkg::TABLE_SIZE];
	logic [7:0] perm_c [pn2h_pkg::TABLE_SIZE];
	logic [7:0] pa_s9;
	logic [7:0] pb_s9;
	logic [7:0] y0_s9;
	logic [7:0] ia0;
	logic [7:0] ia1;
	logic [7:0] ib0;
	logic [7:0] ib1;
	logic [7:0] aa_s10;
	logic [7:0] ab_s10;
	logic [7:0] ba_s10;
	logic [7:0] bb_s10;

	assign ia0 = pa_s9 + y0_s9;
	assign ia1 = pa_s9 + y0_s9 + 8'd1;
	assign ib0 = pb_s9 + y0_s9;
	assign ib1 = pb_s9 + y0_s9 + 8'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ld) begin
				perm_a[widx] <= wval;
				perm_b[widx] <= wval;
				perm_c[widx] <= wval;
			end
			pa_s9  <= perm_a[x0];
			pb_s9  <= perm_a[8'(x0 + 8'd1)];
			y0_s9  <= y0;
			aa_s10 <= perm_b[ia0];
			ab_s10 <= perm_b[ia1];
			ba_s10 <= perm_c[ib0];
			bb_s10 <= perm_c[ib1];
		end
	end

	assign h_aa = aa_s10[2:0];
	assign h_ab = ab_s10[2:0];
	assign h_ba = ba_s10[2:0];
	assign h_bb = bb_s10[2:0];
endmodule
`default_nettype wire

/* hw/rtl/pn2h_blend.sv */
`default_nettype none
module pn2h_blend (
	input  logic        clk,
	input  logic        adv,
	input  logic [2:0]  h_aa,
	input  logic [2:0]  h_ab,
	input  logic [2:0]  h_ba,
	input  logic [2:0]  h_bb,
	input  logic [15:0] xf,
	input  logic [15:0] yf,
	input  logic [16:0] u,
	input  logic [16:0] v,
	input  logic [15:0] amp,
	output logic [25:0] height
);
	logic signed [17:0] dx0, dx1, dy0, dy1;
	logic signed [18:0] d_aa_s11, d_ab_s11, d_ba_s11, d_bb_s11;
	logic signed [19:0] df1, df2;
	logic signed [37:0] pr1_s12, pr2_s12;
	logic signed [18:0] a1_s12, a2_s12;
	logic [16:0]        v_s12, v_s13;
	logic signed [19:0] r1_s13, r2_s13;
	logic signed [20:0] df3;
	logic signed [38:0] pr3_s14;
	logic signed [19:0] r1_s14;
	logic signed [20:0] n_s15;
	logic signed [21:0] nsum;
	logic signed [20:0] m;
	logic signed [37:0] mp_s16;
	logic signed [37:0] hh;
	logic [25:0]        height_s17;

	assign dx0 = $signed({2'b00, xf});
	assign dx1 = dx0 - 18'sd65536;
	assign dy0 = $signed({2'b00, yf});
	assign dy1 = dy0 - 18'sd65536;

	assign df1  = 20'(d_ba_s11) - 20'(d_aa_s11);
	assign df2  = 20'(d_bb_s11) - 20'(d_ab_s11);
	assign df3  = 21'(r2_s13) - 21'(r1_s13);
	assign nsum = 22'(n_s15) + 22'sd65536;
	assign m    = 21'(nsum >>> 1);
	assign hh   = mp_s16 >>> 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_aa_s11 <= pn2h_pkg::grad_dot(h_aa, dx0, dy0);
			d_ba_s11 <= pn2h_pkg::grad_dot(h_ba, dx1, dy0);
			d_ab_s11 <= pn2h_pkg::grad_dot(h_ab, dx0, dy1);
			d_bb_s11 <= pn2h_pkg::grad_dot(h_bb, dx1, dy1);
			pr1_s12  <= $signed({1'b0, u}) * df1;
			pr2_s12  <= $signed({1'b0, u}) * df2;
			a1_s12   <= d_aa_s11;
			a2_s12   <= d_ab_s11;
			v_s12    <= v;
			r1_s13   <= 20'(a1_s12) + 20'(pr1_s12 >>> 16);
			r2_s13   <= 20'(a2_s12) + 20'(pr2_s12 >>> 16);
			v_s13    <= v_s12;
			pr3_s14  <= $signed({1'b0, v_s13}) * df3;
			r1_s14   <= r1_s13;
			n_s15    <= 21'(r1_s14) + 21'(pr3_s14 >>> 16);
			mp_s16   <= m * $signed({1'b0, amp});
			if (hh > 38'sd33554431)
				height_s17 <= 26'h1FFFFFF;
			else if (hh < -38'sd33554432)
				height_s17 <= 26'h2000000;
			else
				height_s17 <= hh[25:0];
		end
	end

	assign height = height_s17;
endmodule
`default_nettype wire

/* hw/rtl/perlin_noise_2d_height_top.sv */
// An accepted evaluate beat passes through every pipeline register before its height beat.
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Table load beats pass down the widx_s/wval_s delay registers, then write the permutation table; no output.
// Reset clears pipeline valid bits and sets configuration to its defaults;
// the permutation table is not cleared.
`default_nettype none
`include "perlin_noise_2d_height_top_assert.svh"
module perlin_noise_2d_height_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	output logic        height_valid,
	input  logic        height_stall,
	output logic signed [25:0] height_value
);
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [15:0] freq_q;
	logic [15:0] amp_q;
	logic        adv;
	logic [17:1] ev_s;
	logic [8:1]  ld_s;
	logic [7:0]  widx_s [1:8];
	logic [7:0]  wval_s [1:8];
	logic [7:0]  cell_x, cell_y;
	logic [15:0] frac_x, frac_y;
	logic [15:0] xf_s9, xf_s10, yf_s9, yf_s10;
	logic [16:0] u_x, v_y;
	logic [2:0]  h_aa, h_ab, h_ba, h_bb;
	logic [25:0] height;

	assign adv        = !ev_s[17] || !height_stall;
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd256;
			height_q <= 13'd256;
			freq_q   <= 16'd1024;
			amp_q    <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pn2h_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[12:0];
				pn2h_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[12:0];
				pn2h_pkg::CFG_FREQUENCY:    freq_q   <= cfg_data;
				pn2h_pkg::CFG_AMPLITUDE:    amp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s <= '0;
			ld_s <= '0;
		end else if (adv) begin
			ev_s <= {ev_s[16:1], item_valid && (func == pn2h_pkg::FUNC_EVAL)};
			ld_s <= {ld_s[7:1], item_valid && (func == pn2h_pkg::FUNC_LOAD)};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			widx_s[1] <= table_index;
			wval_s[1] <= table_value;
			for (int k = 2; k <= 8; k++) begin
				widx_s[k] <= widx_s[k-1];
				wval_s[k] <= wval_s[k-1];
			end
			xf_s9  <= frac_x;
			xf_s10 <= xf_s9;
			yf_s9  <= frac_y;
			yf_s10 <= yf_s9;
		end
	end

	pn2h_coord u_coord_x (
		.clk(clk), .adv(adv), .coord(pixel_x), .dim(width_q), .freq(freq_q),
		.cell_idx(cell_x), .frac(frac_x)
	);

	pn2h_coord u_coord_y (
		.clk(clk), .adv(adv), .coord(pixel_y), .dim(height_q), .freq(freq_q),
		.cell_idx(cell_y), .frac(frac_y)
	);

	pn2h_fade u_fade_x (.clk(clk), .adv(adv), .t(frac_x), .u(u_x));
	pn2h_fade u_fade_y (.clk(clk), .adv(adv), .t(frac_y), .u(v_y));

	pn2h_hash u_hash (
		.clk(clk), .adv(adv), .ld(ld_s[8]), .widx(widx_s[8]), .wval(wval_s[8]),
		.x0(cell_x), .y0(cell_y),
		.h_aa(h_aa), .h_ab(h_ab), .h_ba(h_ba), .h_bb(h_bb)
	);

	pn2h_blend u_blend (
		.clk(clk), .adv(adv),
		.h_aa(h_aa), .h_ab(h_ab), .h_ba(h_ba), .h_bb(h_bb),
		.xf(xf_s10), .yf(yf_s10), .u(u_x), .v(v_y), .amp(amp_q),
		.height(height)
	);

	assign height_valid = ev_s[17];
	assign height_value = $signed(height);

	`PN2H_ASSERT_IMPL(a_stall_holds_input, ev_s[17] && height_stall, item_stall)
	`PN2H_ASSERT_IMPL(a_single_kind_at_write, ld_s[8], !ev_s[8])
	`PN2H_ASSERT_NEXT(a_eval_enters, item_valid && !item_stall && func, ev_s[1])
	`PN2H_ASSERT_NEXT(a_eval_leaves, ev_s[16] && adv, height_valid)
endmodule
`default_nettype wire

/* sim/tb_perlin_noise_2d_height_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_perlin_noise_2d_height_top;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        func = pn2h_pkg::FUNC_LOAD;
	logic [7:0]  table_index = '0;
	logic [7:0]  table_value = '0;
	logic [11:0] pixel_x = '0;
	logic [11:0] pixel_y = '0;
	logic        height_valid;
	logic        height_stall = 1'b0;
	logic signed [25:0] height_value;

	logic [7:0]  perm_copy [256];
	logic [12:0] width_reg, height_reg;
	logic [15:0] freq_reg, amp_reg;
	logic signed [25:0] height_queue [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	perlin_noise_2d_height_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .table_index(table_index), .table_value(table_value),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.height_valid(height_valid), .height_stall(height_stall),
		.height_value(height_value)
	);

	always #4 clk = ~clk;

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> pn2h_pkg::FRAC_BITS;
	endfunction

	function automatic longint fade_curve(longint t);
		longint t2, t3, p;
		t2 = qmul(t, t);
		t3 = qmul(t2, t);
		p = qmul(t, 6 * t - 15 * 65536) + 10 * 65536;
		return qmul(t3, p);
	endfunction

	function automatic longint corner_dot(logic [7:0] h, longint dx, longint dy);
		case (h[2:0])
			3'd0: return dx + dy;
			3'd1: return dx - dy;
			3'd2: return dy - dx;
			3'd3: return -dx - dy;
			3'd4: return dx;
			3'd5: return -dx;
			3'd6: return dy;
			default: return -dy;
		endcase
	endfunction

	function automatic longint centred_scaled(logic [11:0] c, logic [12:0] dim);
		longint d, q;
		d = dim;
		if (d == 0)
			d = 1;
		else if (d > pn2h_pkg::MAX_DIM)
			d = pn2h_pkg::MAX_DIM;
		q = ((longint'(c) << pn2h_pkg::FRAC_BITS) / d) - 32768;
		return (q * longint'(freq_reg)) >>> 8;
	endfunction

	function automatic logic signed [25:0] predict_height(logic [11:0] px, logic [11:0] py);
		longint sx, sy, xf, yf, u, v, r1, r2, n, m, h, one;
		logic [7:0] x0, y0, pa, pb, aa, ab, ba, bb;
		one = 65536;
		sx = centred_scaled(px, width_reg);
		sy = centred_scaled(py, height_reg);
		x0 = sx[23:16];
		y0 = sy[23:16];
		xf = sx & 64'hFFFF;
		yf = sy & 64'hFFFF;
		u = fade_curve(xf);
		v = fade_curve(yf);
		pa = perm_copy[x0];
		pb = perm_copy[8'(x0 + 8'd1)];
		aa = perm_copy[8'(pa + y0)];
		ab = perm_copy[8'(pa + y0 + 8'd1)];
		ba = perm_copy[8'(pb + y0)];
		bb = perm_copy[8'(pb + y0 + 8'd1)];
		r1 = corner_dot(aa, xf, yf);
		r1 = r1 + qmul(u, corner_dot(ba, xf - one, yf) - r1);
		r2 = corner_dot(ab, xf, yf - one);
		r2 = r2 + qmul(u, corner_dot(bb, xf - one, yf - one) - r2);
		n = r1 + qmul(v, r2 - r1);
		m = (n + one) >>> 1;
		h = (m * longint'(amp_reg)) >>> 8;
		if (h > 33554431)
			h = 33554431;
		if (h < -33554432)
			h = -33554432;
		return 26'(h);
	endfunction

	always @(posedge clk) begin
		height_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && height_valid && !height_stall) begin
			if (height_queue.size() == 0) begin
				$error("height_value: unexpected beat, actual %0d", height_value);
				mismatches++;
			end else begin
				if (height_value !== height_queue[0]) begin
					$error("height_value: expected %0d, actual %0d",
						height_queue[0], height_value);
					mismatches++;
				end
				void'(height_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (height_valid && !height_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_perlin_noise_2d_height_top: FAIL");
			$finish;
		end
	end

	task automatic send_beat(logic f, logic [7:0] ti, logic [7:0] tv,
			logic [11:0] px, logic [11:0] py);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		func <= f;
		table_index <= ti;
		table_value <= tv;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (item_stall);
		if (f == pn2h_pkg::FUNC_LOAD)
			perm_copy[ti] = tv;
		else
			height_queue.push_back(predict_height(px, py));
	endtask

	task automatic wait_results;
		item_valid <= 1'b0;
		do @(posedge clk); while (height_queue.size() != 0);
	endtask

	task automatic drain;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pn2h_pkg::CFG_IMAGE_WIDTH:  width_reg = val[12:0];
			pn2h_pkg::CFG_IMAGE_HEIGHT: height_reg = val[12:0];
			pn2h_pkg::CFG_FREQUENCY:    freq_reg = val;
			pn2h_pkg::CFG_AMPLITUDE:    amp_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] w, logic [15:0] h, logic [15:0] fr,
			logic [15:0] am);
		write_reg(pn2h_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(pn2h_pkg::CFG_IMAGE_HEIGHT, h);
		write_reg(pn2h_pkg::CFG_FREQUENCY, fr);
		write_reg(pn2h_pkg::CFG_AMPLITUDE, am);
	endtask

	task automatic test_fill_table;
		for (int i = 0; i < 256; i++)
			send_beat(pn2h_pkg::FUNC_LOAD, 8'(i), 8'($urandom_range(255)), '0, '0);
		send_beat(pn2h_pkg::FUNC_LOAD, 8'd0, 8'd255, 12'hFFF, 12'hFFF);
		send_beat(pn2h_pkg::FUNC_LOAD, 8'd255, 8'd0, '0, '0);
	endtask

	task automatic test_directed;
		send_beat(pn2h_pkg::FUNC_EVAL, 8'hFF, 8'hFF, 12'd0, 12'd0);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd4095, 12'd4095);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd128, 12'd64);
		set_config(16'd0, 16'h1FFF, 16'hFFFF, 16'hFFFF);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd0, 12'd0);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd4095, 12'd1);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd1, 12'd2048);
		set_config(16'd1, 16'd4096, 16'd0, 16'd0);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd4095, 12'd4095);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd0, 12'd0);
		set_config(16'd4096, 16'd4097, 16'd1, 16'hFFFF);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd2048, 12'd4095);
		send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'd17, 12'd3000);
		set_config(16'd3, 16'd5, 16'd40000, 16'hFFFF);
		for (int i = 0; i < 8; i++)
			send_beat(pn2h_pkg::FUNC_EVAL, '0, '0, 12'($urandom_range(4095)),
				12'($urandom_range(4095)));
		drain();
	endtask

	task automatic test_random(int count);
		logic [11:0] px, py;
		for (int i = 0; i < count; i++) begin
			if (i % 200 == 199)
				wait_results();
			if ($urandom_range(99) < 15) begin
				send_beat(pn2h_pkg::FUNC_LOAD, 8'($urandom_range(255)),
					8'($urandom_range(255)),
					12'($urandom_range(4095)), 12'($urandom_range(4095)));
			end else begin
				px = 12'($urandom_range(4095));
				py = 12'($urandom_range(4095));
				if ($urandom_range(3) == 0)
					px = 12'($urandom_range(width_reg > 0 ? width_reg - 1 : 0));
				if ($urandom_range(3) == 0)
					py = 12'($urandom_range(height_reg > 0 ? height_reg - 1 : 0));
				send_beat(pn2h_pkg::FUNC_EVAL, 8'($urandom_range(255)),
					8'($urandom_range(255)), px, py);
			end
		end
		drain();
	endtask

	initial begin
		width_reg = 13'd256;
		height_reg = 13'd256;
		freq_reg = 16'd1024;
		amp_reg = 16'd256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_table();
		test_directed();

		send_idle_pct = 37;
		stall_pct = 58;
		set_config(16'd640, 16'd480, 16'd2048, 16'd256);
		test_random(475);

		send_idle_pct = 58;
		stall_pct = 37;
		set_config(16'h1FFF, 16'd0, 16'($urandom_range(65535)), 16'hFFFF);
		test_random(475);

		send_idle_pct = 0;
		stall_pct = 0;
		set_config(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
		test_random(475);

		drain();
		if (mismatches == 0)
			$display("tb_perlin_noise_2d_height_top: PASS");
		else
			$display("tb_perlin_noise_2d_height_top: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
